// ===== design/tvbb_pkg.sv =====
// Shared types and constants for the transformed vertex bounding box.
`default_nettype none

package tvbb_pkg;

	// Coordinate width default and fixed-point layout
	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS       = 16;
	localparam int WEIGHT_W        = 32;
	localparam int CFG_DATA_W      = 2 * WEIGHT_W;
	localparam int AXES            = 3;

	// Configuration register map
	localparam int CFG_REGS  = 6;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_XY = 3'd0,
		REG_X_ZT = 3'd1,
		REG_Y_XY = 3'd2,
		REG_Y_ZT = 3'd3,
		REG_Z_XY = 3'd4,
		REG_Z_ZT = 3'd5
	} cfg_reg_t;

	// Reset gives the identity transform
	localparam logic [CFG_DATA_W-1:0] RST_X_XY = 64'h0000_0000_0001_0000;
	localparam logic [CFG_DATA_W-1:0] RST_X_ZT = 64'h0000_0000_0000_0000;
	localparam logic [CFG_DATA_W-1:0] RST_Y_XY = 64'h0001_0000_0000_0000;
	localparam logic [CFG_DATA_W-1:0] RST_Y_ZT = 64'h0000_0000_0000_0000;
	localparam logic [CFG_DATA_W-1:0] RST_Z_XY = 64'h0000_0000_0000_0000;
	localparam logic [CFG_DATA_W-1:0] RST_Z_ZT = 64'h0000_0000_0001_0000;

endpackage

`default_nettype wire

// ===== design/tvbb_if.sv =====
// Channel interfaces: vertex input, box result and configuration write.
`default_nettype none

interface tvbb_vertex_if import tvbb_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] vertex_x;
	logic signed [COORD_WIDTH-1:0] vertex_y;
	logic signed [COORD_WIDTH-1:0] vertex_z;
	logic                          last_vertex;

	modport source (output valid, vertex_x, vertex_y, vertex_z, last_vertex, input ready);
	modport sink   (input valid, vertex_x, vertex_y, vertex_z, last_vertex, output ready);
endinterface

interface tvbb_box_if import tvbb_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] min_x;
	logic signed [COORD_WIDTH-1:0] min_y;
	logic signed [COORD_WIDTH-1:0] min_z;
	logic signed [COORD_WIDTH-1:0] max_x;
	logic signed [COORD_WIDTH-1:0] max_y;
	logic signed [COORD_WIDTH-1:0] max_z;
	logic                          box_complete;

	modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z, box_complete,
		input ready);
	modport sink   (input valid, min_x, min_y, min_z, max_x, max_y, max_z, box_complete,
		output ready);
endinterface

interface tvbb_cfg_if import tvbb_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  reg_index;
	logic [CFG_DATA_W-1:0] wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

// ===== design/transformed_vertex_bounding_box.sv =====
// Top level: affine transform of a vertex stream and running axis-aligned bounding box.
// A result is offered once its vertex has passed the input register, product register,
//   partial-sum register, saturated-point register and box register.
// Throughput: one vertex per cycle; each stage advances when it is empty or the next one
//   moves, so bubbles collapse and a held result does not stop earlier stages filling.
// Reset: arst_n clears all stage valids, loads the identity transform, zeroes the corners
//   and marks the box empty. Configuration writes are always taken.
`default_nettype none

module transformed_vertex_bounding_box import tvbb_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	tvbb_vertex_if.sink  vertex,
	tvbb_box_if.source   box,
	tvbb_cfg_if.sink     cfg
);

	// Derived widths
	// integer part of a coordinate; a single sign bit when there is no integer part
	localparam int HI_W  = (COORD_WIDTH > FRAC_BITS) ? COORD_WIDTH - FRAC_BITS : 1;
	localparam int LO_W  = FRAC_BITS + 1;               // fraction part, zero-extended
	localparam int PH_W  = HI_W + WEIGHT_W;
	localparam int PL_W  = LO_W + WEIGHT_W;
	localparam int HS_W  = PH_W + 2;
	localparam int LS_W  = PL_W + 2;
	localparam int ACC_W = ((HS_W + FRAC_BITS > LS_W) ? HS_W + FRAC_BITS : LS_W) + 1;
	localparam int SH_W  = ACC_W - FRAC_BITS;

	localparam logic signed [COORD_WIDTH-1:0] SAT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] SAT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	// Configuration registers
	logic [CFG_DATA_W-1:0] cfg_q [CFG_REGS];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[REG_X_XY] <= RST_X_XY;
			cfg_q[REG_X_ZT] <= RST_X_ZT;
			cfg_q[REG_Y_XY] <= RST_Y_XY;
			cfg_q[REG_Y_ZT] <= RST_Y_ZT;
			cfg_q[REG_Z_XY] <= RST_Z_XY;
			cfg_q[REG_Z_ZT] <= RST_Z_ZT;
		end else if (cfg.valid && cfg.reg_index <= REG_Z_ZT) begin
			cfg_q[cfg.reg_index] <= cfg.wdata;
		end
	end

	// Pipeline registers
	logic                          v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic                          last_s1, last_s2, last_s3, last_s4;
	logic signed [COORD_WIDTH-1:0] coord_s1 [AXES];
	logic signed [PH_W-1:0]        ph_s2 [AXES][AXES];
	logic signed [PL_W-1:0]        pl_s2 [AXES][AXES];
	logic signed [WEIGHT_W-1:0]    trans_s2 [AXES];
	logic signed [HS_W-1:0]        hsum_s3 [AXES];
	logic signed [LS_W-1:0]        lsum_s3 [AXES];
	logic signed [COORD_WIDTH-1:0] point_s4 [AXES];

	// Box state, which is also the result register
	logic signed [COORD_WIDTH-1:0] low_q [AXES];
	logic signed [COORD_WIDTH-1:0] high_q [AXES];
	logic                          box_empty_q;
	logic                          box_complete_q;

	// Stage advance: a stage loads when it is empty or its item moves on
	logic en_out, en_s4, en_s3, en_s2, en_s1, commit;

	assign en_out = !out_valid_q || box.ready;
	assign en_s4  = !v_s4 || en_out;
	assign en_s3  = !v_s3 || en_s4;
	assign en_s2  = !v_s2 || en_s3;
	assign en_s1  = !v_s1 || en_s2;
	assign commit = v_s4 && en_out;

	assign vertex.ready = en_s1;

	// Valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1)  v_s1        <= vertex.valid;
			if (en_s2)  v_s2        <= v_s1;
			if (en_s3)  v_s3        <= v_s2;
			if (en_s4)  v_s4        <= v_s3;
			if (en_out) out_valid_q <= v_s4;
		end
	end

	// Stage 1: input register
	always_ff @(posedge clk) begin
		if (en_s1) begin
			coord_s1[0] <= vertex.vertex_x;
			coord_s1[1] <= vertex.vertex_y;
			coord_s1[2] <= vertex.vertex_z;
			last_s1     <= vertex.last_vertex;
		end
	end

	// Last mark follows the item down the stages
	always_ff @(posedge clk) begin
		if (en_s2) last_s2 <= last_s1;
		if (en_s3) last_s3 <= last_s2;
		if (en_s4) last_s4 <= last_s3;
	end

	for (genvar a = 0; a < AXES; a++) begin : g_axis
		logic signed [WEIGHT_W-1:0] wgt [AXES];
		logic signed [WEIGHT_W-1:0] trans;
		logic signed [ACC_W-1:0]    acc;
		logic signed [SH_W-1:0]     shifted;
		logic                       in_range;

		// Weights of this output axis, one register pair per axis
		assign wgt[0] = cfg_q[2*a][WEIGHT_W-1:0];
		assign wgt[1] = cfg_q[2*a][CFG_DATA_W-1:WEIGHT_W];
		assign wgt[2] = cfg_q[2*a+1][WEIGHT_W-1:0];
		assign trans  = cfg_q[2*a+1][CFG_DATA_W-1:WEIGHT_W];

		// Stage 2: integer-part and fraction-part products, each coordinate part times a 32-bit weight
		for (genvar k = 0; k < AXES; k++) begin : g_prod
			logic signed [HI_W-1:0] c_hi;
			logic signed [LO_W-1:0] c_lo;

			assign c_hi = HI_W'(coord_s1[k] >>> FRAC_BITS);
			assign c_lo = {1'b0, coord_s1[k][FRAC_BITS-1:0]};

			always_ff @(posedge clk) begin
				if (en_s2) begin
					ph_s2[a][k] <= c_hi * wgt[k];
					pl_s2[a][k] <= c_lo * wgt[k];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en_s2) trans_s2[a] <= trans;
		end

		// Stage 3: integer products plus translation, and fraction products
		always_ff @(posedge clk) begin
			if (en_s3) begin
				hsum_s3[a] <= HS_W'(ph_s2[a][0]) + HS_W'(ph_s2[a][1])
					+ HS_W'(ph_s2[a][2]) + HS_W'(trans_s2[a]);
				lsum_s3[a] <= LS_W'(pl_s2[a][0]) + LS_W'(pl_s2[a][1])
					+ LS_W'(pl_s2[a][2]);
			end
		end

		// Stage 4: align, floor shift and saturate
		assign acc      = (ACC_W'(hsum_s3[a]) <<< FRAC_BITS) + ACC_W'(lsum_s3[a]);
		assign shifted  = acc[ACC_W-1:FRAC_BITS];
		assign in_range = (shifted[SH_W-1:COORD_WIDTH-1] == '0)
			|| (shifted[SH_W-1:COORD_WIDTH-1] == '1);

		always_ff @(posedge clk) begin
			if (en_s4) begin
				if (in_range) begin
					point_s4[a] <= shifted[COORD_WIDTH-1:0];
				end else if (shifted[SH_W-1]) begin
					point_s4[a] <= SAT_MIN;
				end else begin
					point_s4[a] <= SAT_MAX;
				end
			end
		end

		// Box update: first vertex of a model loads both corners
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				low_q[a]  <= '0;
				high_q[a] <= '0;
			end else if (commit) begin
				if (box_empty_q || point_s4[a] < low_q[a]) begin
					low_q[a] <= point_s4[a];
				end
				if (box_empty_q || point_s4[a] > high_q[a]) begin
					high_q[a] <= point_s4[a];
				end
			end
		end
	end

	// Empty flag and end-of-model mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_empty_q    <= 1'b1;
			box_complete_q <= 1'b0;
		end else if (commit) begin
			box_empty_q    <= last_s4;
			box_complete_q <= last_s4;
		end
	end

	// Result port
	assign box.valid        = out_valid_q;
	assign box.min_x        = low_q[0];
	assign box.min_y        = low_q[1];
	assign box.min_z        = low_q[2];
	assign box.max_x        = high_q[0];
	assign box.max_y        = high_q[1];
	assign box.max_z        = high_q[2];
	assign box.box_complete = box_complete_q;

	// Checks
	a_box_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		box.valid |-> (low_q[0] <= high_q[0]) && (low_q[1] <= high_q[1])
			&& (low_q[2] <= high_q[2]))
		else $error("bounding box corners out of order");

	a_empty_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		commit && !last_s4 |=> !box_empty_q)
		else $error("box still empty after a vertex inside a model");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 && v_s3 && v_s4 && out_valid_q && !box.ready |-> !vertex.ready)
		else $error("vertex taken while every stage is held");

endmodule

`default_nettype wire
